// ===== rtl/aar_pkg.sv =====
// shared types and constants for the bounding box accumulator
`default_nettype none

package aar_pkg;

    localparam int COORD_BITS = 24;
    localparam int RAD_BITS   = COORD_BITS + 1;
    localparam int EPS_BITS   = 23;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic                         start_new;
        logic signed [COORD_BITS-1:0] lo_x;
        logic signed [COORD_BITS-1:0] lo_y;
        logic signed [COORD_BITS-1:0] lo_z;
        logic signed [COORD_BITS-1:0] hi_x;
        logic signed [COORD_BITS-1:0] hi_y;
        logic signed [COORD_BITS-1:0] hi_z;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                   moved_count;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
        logic [RAD_BITS-1:0]          radius;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_ROOT,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/aar_sqrt.sv =====
// iterative restoring square root, one root bit per cycle, saturating
`default_nettype none

module aar_sqrt #(
    parameter int IN_W = 52
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [IN_W-1:0]              radicand,
    output logic                              done,
    output logic [aar_pkg::RAD_BITS-1:0]      root
);

    localparam int RB    = aar_pkg::RAD_BITS;
    localparam int SQ_W  = 2 * RB;
    localparam int EXT_W = (IN_W > SQ_W) ? IN_W : SQ_W;
    localparam int RW    = RB + 2;
    localparam int CW    = $clog2(RB + 1);

    logic [EXT_W-1:0] rad_ext;
    logic [SQ_W-1:0]  rad_reg, rad_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [RB-1:0]    root_reg, root_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic [RW-1:0]    rem_t;
    logic [RW-1:0]    trial;

    assign rad_ext = EXT_W'(radicand);
    assign rem_t   = {rem_reg[RW-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = rad_ext[SQ_W-1:0];
            sat_next  = (rad_ext >> SQ_W) != '0;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {root_reg[RB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sat_reg  <= sat_next;
    end

    assign done = done_reg;
    assign root = sat_reg ? {RB{1'b1}} : root_reg;

endmodule

`default_nettype wire

// ===== rtl/aabb_accumulate_radius.sv =====
// top level: box merge, shared squaring unit and sequencer around the square root
// no bound moved and start_new low: idle, finish state, output register; otherwise
// the sum state (three squared extents through one multiplier) and the root state
// come before the finish state. Items are taken only in the idle state, and
// a finished result waits in the output register while the next item is taken
// reset: box empty (min at largest, max at smallest), radius 0, epsilon 1
`default_nettype none

module aabb_accumulate_radius #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [aar_pkg::EPS_BITS-1:0]  cfg_data,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire aar_pkg::in_item_t             item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output aar_pkg::out_item_t                 result
);

    localparam int CB    = aar_pkg::COORD_BITS;
    localparam int EB    = aar_pkg::EPS_BITS;
    localparam int SQ_B  = 2 * CB;
    localparam int EPS_B = EB + FRAC_BITS;
    localparam int SUM_W = ((SQ_B > EPS_B) ? SQ_B : EPS_B) + 2;

    aar_pkg::state_t state_reg, state_next;

    logic signed [CB-1:0]       box_min_reg [3];
    logic signed [CB-1:0]       box_max_reg [3];
    logic signed [CB-1:0]       min_new [3];
    logic signed [CB-1:0]       max_new [3];
    logic signed [CB-1:0]       lo_in [3];
    logic signed [CB-1:0]       hi_in [3];
    logic [aar_pkg::RAD_BITS-1:0] radius_reg;
    logic [EB-1:0]              eps_reg;
    logic [2:0]                 moved_reg;
    logic [2:0]                 moved;
    logic [1:0]                 cnt_reg, cnt_next;
    logic [SUM_W-1:0]           prod_reg;
    logic [SUM_W-1:0]           sum_reg;
    aar_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    logic                       accept;
    logic                       out_load;
    logic                       sq_start;
    logic                       sq_done;
    logic [aar_pkg::RAD_BITS-1:0] sq_root;
    logic signed [CB-1:0]       sel_min;
    logic signed [CB-1:0]       sel_max;
    logic signed [CB:0]         ext;
    logic                       below;
    logic [CB-1:0]              mag;
    logic [SQ_B-1:0]            sq;
    logic [SUM_W-1:0]           term;

    assign lo_in[0] = item.lo_x;
    assign lo_in[1] = item.lo_y;
    assign lo_in[2] = item.lo_z;
    assign hi_in[0] = item.hi_x;
    assign hi_in[1] = item.hi_y;
    assign hi_in[2] = item.hi_z;

    assign item_ready = (state_reg == aar_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    // merge
    always_comb
    begin
        logic signed [CB-1:0] base_min;
        logic signed [CB-1:0] base_max;
        moved = 3'd0;
        for (int i = 0; i < 3; i++)
        begin
            base_min = item.start_new ? aar_pkg::COORD_MAX : box_min_reg[i];
            base_max = item.start_new ? aar_pkg::COORD_MIN : box_max_reg[i];
            min_new[i] = base_min;
            max_new[i] = base_max;
            if (hi_in[i] > base_max)
            begin
                max_new[i] = hi_in[i];
                moved = moved + 3'd1;
            end
            if (lo_in[i] < base_min)
            begin
                min_new[i] = lo_in[i];
                moved = moved + 3'd1;
            end
        end
    end

    // per-axis term through the shared multiplier
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                sel_min = box_min_reg[0];
                sel_max = box_max_reg[0];
            end
            2'd1:
            begin
                sel_min = box_min_reg[1];
                sel_max = box_max_reg[1];
            end
            default:
            begin
                sel_min = box_min_reg[2];
                sel_max = box_max_reg[2];
            end
        endcase
    end

    assign ext   = (CB+1)'(sel_max) - (CB+1)'(sel_min);
    assign below = ext < $signed({{(CB+1-EB){1'b0}}, eps_reg});
    assign mag   = ext[CB-1:0];
    assign sq    = mag * mag;
    assign term  = below ? (SUM_W'(eps_reg) << FRAC_BITS) : SUM_W'(sq);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_start   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            aar_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = 2'd0;
                    if (moved != 3'd0 || item.start_new)
                        state_next = aar_pkg::ST_SUM;
                    else
                        state_next = aar_pkg::ST_FIN;
                end
            end
            aar_pkg::ST_SUM:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = aar_pkg::ST_ROOT;
            end
            aar_pkg::ST_ROOT:
            begin
                if (cnt_reg == 2'd0)
                begin
                    sq_start = 1'b1;
                    cnt_next = 2'd1;
                end
                if (sq_done)
                    state_next = aar_pkg::ST_FIN;
            end
            aar_pkg::ST_FIN:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = aar_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aar_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aar_pkg::ST_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            eps_reg       <= EB'(1);
            radius_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= aar_pkg::COORD_MAX;
                box_max_reg[i] <= aar_pkg::COORD_MIN;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                eps_reg <= cfg_data;
            if (accept)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    box_min_reg[i] <= min_new[i];
                    box_max_reg[i] <= max_new[i];
                end
            end
            if (state_reg == aar_pkg::ST_ROOT && sq_done)
                radius_reg <= sq_root;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            moved_reg <= moved;
            sum_reg   <= '0;
        end
        if (state_reg == aar_pkg::ST_SUM)
        begin
            prod_reg <= term;
            if (cnt_reg != 2'd0)
                sum_reg <= sum_reg + prod_reg;
        end
        if (out_load)
        begin
            out_reg.moved_count <= moved_reg;
            out_reg.min_x       <= box_min_reg[0];
            out_reg.min_y       <= box_min_reg[1];
            out_reg.min_z       <= box_min_reg[2];
            out_reg.max_x       <= box_max_reg[0];
            out_reg.max_y       <= box_max_reg[1];
            out_reg.max_z       <= box_max_reg[2];
            out_reg.radius      <= radius_reg;
        end
    end

    aar_sqrt #(
        .IN_W (SUM_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == aar_pkg::ST_ROOT)
        else $error("square root finished outside root state");

    a_no_move_skip: assert property (@(posedge clk) disable iff (!rst_n)
        accept && moved == 3'd0 && !item.start_new |=> state_reg == aar_pkg::ST_FIN)
        else $error("unmoved item did not skip the radius");

    a_moved_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.moved_count <= 3'd6)
        else $error("moved count above six");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || result_ready)
        else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== verif/aabb_box_checker.sv =====
`timescale 1ns / 1ps
// checker for the bounding box accumulator: follows its channels, predicts each result, compares

module aabb_box_checker #(
    parameter int FRAC_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aar_pkg::EPS_BITS-1:0] cfg_data,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  aar_pkg::in_item_t            item,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  aar_pkg::out_item_t           result,
    output int                           fail_count,
    output int                           results_seen,
    output int                           pending
);

    localparam int CB = aar_pkg::COORD_BITS;
    localparam int RB = aar_pkg::RAD_BITS;
    localparam int EB = aar_pkg::EPS_BITS;

    logic signed [CB-1:0] acc_min [3];
    logic signed [CB-1:0] acc_max [3];
    logic [RB-1:0]        acc_radius;
    logic [EB-1:0]        min_extent;
    aar_pkg::out_item_t   expected_boxes [$];

    function automatic void empty_box();
        for (int a = 0; a < 3; a++)
        begin
            acc_min[a] = aar_pkg::COORD_MAX;
            acc_max[a] = aar_pkg::COORD_MIN;
        end
    endfunction

    function automatic longint unsigned axis_square(input logic signed [CB-1:0] lo,
                                                    input logic signed [CB-1:0] hi);
        longint ext;
        ext = longint'(hi) - longint'(lo);
        if (ext < longint'(min_extent))
            return longint'(min_extent) << FRAC_BITS;
        return longint'(ext) * longint'(ext);
    endfunction

    function automatic logic [RB-1:0] floor_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = RB - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= s)
                root = trial;
        end
        return root[RB-1:0];
    endfunction

    function automatic aar_pkg::out_item_t merge_box(input aar_pkg::in_item_t v);
        logic signed [CB-1:0] lo [3];
        logic signed [CB-1:0] hi [3];
        int                   moved;
        longint unsigned      sum;
        aar_pkg::out_item_t   r;
        lo[0] = v.lo_x;
        lo[1] = v.lo_y;
        lo[2] = v.lo_z;
        hi[0] = v.hi_x;
        hi[1] = v.hi_y;
        hi[2] = v.hi_z;
        moved = 0;
        if (v.start_new)
            empty_box();
        for (int a = 0; a < 3; a++)
        begin
            if (acc_max[a] < hi[a])
            begin
                acc_max[a] = hi[a];
                moved++;
            end
            if (acc_min[a] > lo[a])
            begin
                acc_min[a] = lo[a];
                moved++;
            end
        end
        if (moved != 0 || v.start_new)
        begin
            sum = 0;
            for (int a = 0; a < 3; a++)
                sum += axis_square(acc_min[a], acc_max[a]);
            acc_radius = floor_sqrt(sum);
        end
        r.moved_count = moved[2:0];
        r.min_x       = acc_min[0];
        r.min_y       = acc_min[1];
        r.min_z       = acc_min[2];
        r.max_x       = acc_max[0];
        r.max_y       = acc_max[1];
        r.max_z       = acc_max[2];
        r.radius      = acc_radius;
        return r;
    endfunction

    task automatic check_field(input string name, input longint exp, input longint act);
        if (exp != act)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         name, results_seen, exp, act);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        aar_pkg::out_item_t want;
        if (!rst_n)
        begin
            empty_box();
            acc_radius = '0;
            min_extent = EB'(1);
            expected_boxes.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
                min_extent = cfg_data;
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_boxes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with no item outstanding", results_seen);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    check_field("moved_count", want.moved_count, result.moved_count);
                    check_field("min_x", want.min_x, result.min_x);
                    check_field("min_y", want.min_y, result.min_y);
                    check_field("min_z", want.min_z, result.min_z);
                    check_field("max_x", want.max_x, result.max_x);
                    check_field("max_y", want.max_y, result.max_y);
                    check_field("max_z", want.max_z, result.max_z);
                    check_field("radius", want.radius, result.radius);
                end
            end
            if (item_valid && item_ready)
                expected_boxes.push_back(merge_box(item));
            pending = expected_boxes.size();
        end
    end

endmodule

// ===== verif/tb_aabb_accumulate_radius.sv =====
`timescale 1ns / 1ps
// testbench top for the bounding box accumulator: clock, reset, stimulus and verdict

module tb_aabb_accumulate_radius;

    localparam int CB          = aar_pkg::COORD_BITS;
    localparam int EB          = aar_pkg::EPS_BITS;
    localparam int CMAX        = 8388607;
    localparam int CMIN        = -8388608;
    localparam int EPS_TOP     = 8388607;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [EB-1:0]      cfg_data     = '0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    aar_pkg::in_item_t  item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    aar_pkg::out_item_t result;

    int fail_count;
    int results_seen;
    int pending;
    int sent_total     = 0;
    int eps_settings   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_req       = 1'b0;
    bit hold_taken     = 1'b0;
    int hold_left      = 0;
    int stall_cycles   = 0;

    aabb_accumulate_radius #(
        .FRAC_BITS(12)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    aabb_box_checker #(
        .FRAC_BITS(12)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .fail_count  (fail_count),
        .results_seen(results_seen),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic aar_pkg::in_item_t make_box(input logic start, input int lx,
                                                   input int ly, input int lz, input int hx,
                                                   input int hy, input int hz);
        aar_pkg::in_item_t v;
        v.start_new = start;
        v.lo_x      = lx[CB-1:0];
        v.lo_y      = ly[CB-1:0];
        v.lo_z      = lz[CB-1:0];
        v.hi_x      = hx[CB-1:0];
        v.hi_y      = hy[CB-1:0];
        v.hi_z      = hz[CB-1:0];
        return v;
    endfunction

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return aar_pkg::COORD_MAX;
            1:       return aar_pkg::COORD_MIN;
            2, 3:    return CB'($urandom());
            default: return CB'($urandom_range(131072) - 65536);
        endcase
    endfunction

    // kinds: ordered box, vertex, inverted corners, unrelated corners
    function automatic void pick_span(input int kind,
                                      output logic signed [CB-1:0] lo,
                                      output logic signed [CB-1:0] hi);
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        a = pick_coord();
        b = pick_coord();
        if (kind <= 5)
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
        else if (kind <= 7)
        begin
            lo = a;
            hi = a;
        end
        else if (kind == 8)
        begin
            lo = (a < b) ? b : a;
            hi = (a < b) ? a : b;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic aar_pkg::in_item_t pick_box(input logic start);
        aar_pkg::in_item_t v;
        int                kind;
        kind = $urandom_range(9);
        v.start_new = start;
        pick_span(kind, v.lo_x, v.hi_x);
        pick_span(kind, v.lo_y, v.hi_y);
        pick_span(kind, v.lo_z, v.hi_z);
        return v;
    endfunction

    task automatic send_item(input aar_pkg::in_item_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (results_seen < sent_total)
            @(posedge clk);
    endtask

    task automatic set_min_extent(input int value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value[EB-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        eps_settings++;
    endtask

    // short sequences opened by start_new, with a little noise on the flag
    task automatic run_random(input int count, input bit pressure);
        int   seq_left;
        logic start;
        seq_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (seq_left == 0)
            begin
                seq_left = $urandom_range(12, 1);
                start    = 1'b1;
            end
            else
            begin
                start = ($urandom_range(19) == 0);
            end
            seq_left--;
            if (pressure && n == 60)
                hold_req = 1'b1;
            send_item(pick_box(start));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_min_extent(1);
        // first item sees the reset box
        send_item(make_box(0, 100, 200, 300, 100, 200, 300));
        send_item(make_box(0, 100, 200, 300, 100, 200, 300));
        send_item(make_box(1, 0, 0, 0, 0, 0, 0));
        send_item(make_box(0, -4096, 0, 0, 4096, 0, 0));
        send_item(make_box(0, 0, -8192, 0, 0, 0, 0));
        send_item(make_box(0, 0, 0, 0, 0, 0, 12288));
        send_item(make_box(1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_item(make_box(0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_item(make_box(1, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_item(make_box(1, 40960, 40960, 40960, -40960, -40960, -40960));
        send_item(make_box(0, -40960, -40960, -40960, 40960, 40960, 40960));
        send_item(make_box(1, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_item(make_box(0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_item(make_box(1, -1, -1, -1, -1, -1, -1));
        send_item(make_box(0, 0, 0, 0, 0, 0, 0));

        set_min_extent(EPS_TOP);
        send_item(make_box(1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_item(make_box(1, 0, 0, 0, 4096, 4096, 4096));
        send_item(make_box(0, CMIN, 0, 0, 4096, 0, 0));

        set_min_extent(0);
        send_item(make_box(1, 5, 5, 5, 5, 5, 5));
        send_item(make_box(0, 5, 5, 4, 5, 6, 5));
        send_item(make_box(1, 7, 7, 7, 6, 6, 6));

        send_idle_pct = 10;
        recv_idle_pct = 57;
        set_min_extent(4096);
        run_random(500, 1'b0);

        send_idle_pct = 57;
        recv_idle_pct = 10;
        set_min_extent(EPS_TOP);
        run_random(300, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_min_extent(0);
        run_random(400, 1'b1);

        set_min_extent($urandom_range(EPS_TOP));
        run_random(500, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d boxes merged and %0d results checked over %0d minimum-extent settings",
                 sent_total, results_seen, eps_settings);
        $display("tb: idling on both sides and one %0d-cycle output stall, %0d mismatches",
                 HOLD_CYCLES, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
